@@ rtl/core/plbb_pkg.sv @@
// ----------------------------------------------------------------------------
// plbb_pkg
// shared types and constants of the paged lcd byte blit core
// ----------------------------------------------------------------------------
package plbb_pkg;

    localparam int PAGE_ROWS     = 8;
    localparam int OP_CHIP_W     = 2;   // up to four chips
    localparam int OP_PAGE_W     = 4;   // up to sixteen pages
    localparam int OP_COL_W      = 8;   // up to 256 columns per chip
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [2:0] {
        MODE_OR      = 3'd0,
        MODE_XOR     = 3'd1,
        MODE_INV_OR  = 3'd2,
        MODE_INV_XOR = 3'd3,
        MODE_REPLACE = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] pixel_byte;
    } t_item;

    typedef struct packed {
        logic       chip;
        logic [2:0] page;
        logic [5:0] column;
        logic [7:0] value;
        logic       last;
    } t_result;

    // classified word waiting for the back end
    typedef struct packed {
        logic [OP_CHIP_W-1:0] chip;
        logic [OP_PAGE_W-1:0] page;
        logic [OP_COL_W-1:0]  col;
        logic [2:0]           shift;
        logic [7:0]           data;
        logic                 spill;
    } t_op;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FETCH,
        BK_MERGE
    } t_back_state;

endpackage

@@ rtl/core/plbb_front.sv @@
// ----------------------------------------------------------------------------
// plbb_front
// range check and address split of incoming words, two-entry queue
// ----------------------------------------------------------------------------
module plbb_front #(
    parameter int CHIP_COLUMNS = 64,
    parameter int CHIP_COUNT   = 2,
    parameter int PAGE_COUNT   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  plbb_pkg::t_item  i_item,
    input  plbb_pkg::t_mode  i_mode,
    input  logic             i_pop,
    output plbb_pkg::t_op    o_head,
    output logic             o_head_valid,
    output logic             o_full
);
    import plbb_pkg::*;

    localparam logic [10:0] X_LIMIT = 11'(CHIP_COLUMNS * CHIP_COUNT);
    localparam logic [8:0]  Y_LIMIT = 9'(PAGE_COUNT * PAGE_ROWS);

    t_op        w_op;
    logic       w_keep;
    t_op        r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        logic [OP_CHIP_W-1:0] chip;
        logic [7:0]           col;
        chip = '0;
        col  = i_item.pos_x;
        for (int k = 1; k < CHIP_COUNT; k++) begin
            if ({3'b000, i_item.pos_x} >= 11'(k * CHIP_COLUMNS)) begin
                chip = OP_CHIP_W'(k);
                col  = i_item.pos_x - 8'(k * CHIP_COLUMNS);
            end
        end
        w_op.chip  = chip;
        w_op.col   = OP_COL_W'(col);
        w_op.page  = OP_PAGE_W'(i_item.pos_y[7:3]);
        w_op.shift = i_item.pos_y[2:0];
        w_op.data  = i_item.pixel_byte;
        w_op.spill = (i_item.pos_y[2:0] != 3'd0) &&
                     (({1'b0, i_item.pos_y[7:3]} + 6'd1) < 6'(PAGE_COUNT));
        // out-of-range words and unused modes are dropped here
        w_keep = ({3'b000, i_item.pos_x} < X_LIMIT) &&
                 ({1'b0, i_item.pos_y} < Y_LIMIT) &&
                 (i_mode <= MODE_REPLACE);
    end

    always_comb begin
        n_cnt = r_cnt;
        if ((i_push && w_keep) && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!(i_push && w_keep) && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push && w_keep) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && w_keep) begin
            r_q[r_wp] <= w_op;
        end
    end

    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_full       = (r_cnt == 2'd2);

endmodule

@@ rtl/core/plbb_back.sv @@
// ----------------------------------------------------------------------------
// plbb_back
// framebuffer memory with read-modify-write sequencer and reset clear pass
// ----------------------------------------------------------------------------
module plbb_back #(
    parameter int CHIP_COLUMNS = 64,
    parameter int CHIP_COUNT   = 2,
    parameter int PAGE_COUNT   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plbb_pkg::t_mode   i_mode,
    input  plbb_pkg::t_op     i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output logic              o_clearing,
    output logic              o_strobe,
    output plbb_pkg::t_result o_result
);
    import plbb_pkg::*;

    localparam int CHIP_W = (CHIP_COUNT > 1) ? $clog2(CHIP_COUNT) : 1;
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W  = $clog2(CHIP_COLUMNS);
    localparam int AW     = CHIP_W + PAGE_W + COL_W;
    localparam int DEPTH  = 2 ** AW;

    logic [7:0]    mem [DEPTH];

    t_back_state   r_state, n_state;
    t_op           r_op, n_op;
    logic          r_second, n_second;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_clr, n_clr;
    logic [7:0]    r_rd_data;
    logic          r_strobe, n_strobe;
    t_result       r_result, n_result;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [7:0]    w_merged;
    logic [OP_PAGE_W-1:0] w_page;

    function automatic logic [AW-1:0] op_addr(t_op op, logic second);
        logic [OP_PAGE_W-1:0] pg;
        pg = op.page + OP_PAGE_W'(second);
        return {op.chip[CHIP_W-1:0], pg[PAGE_W-1:0], op.col[COL_W-1:0]};
    endfunction

    // merge of the fetched byte with the shifted source byte
    always_comb begin
        logic [7:0] placed;
        logic [7:0] inv_placed;
        logic [7:0] keep;
        logic [3:0] rsh;
        rsh = 4'd8 - {1'b0, r_op.shift};
        if (!r_second) begin
            placed     = r_op.data << r_op.shift;
            inv_placed = (~r_op.data) << r_op.shift;
            keep       = ~(BYTE_ONES << r_op.shift);
        end else begin
            placed     = r_op.data >> rsh;
            inv_placed = (~r_op.data) >> rsh;
            keep       = BYTE_ONES << r_op.shift;
        end
        case (i_mode)
            MODE_OR:      w_merged = r_rd_data | placed;
            MODE_XOR:     w_merged = r_rd_data ^ placed;
            MODE_INV_OR:  w_merged = r_rd_data | inv_placed;
            MODE_INV_XOR: w_merged = r_rd_data ^ inv_placed;
            default:      w_merged = (r_rd_data & keep) | placed;
        endcase
    end

    assign w_page = r_op.page + OP_PAGE_W'(r_second);

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_second = r_second;
        n_addr   = r_addr;
        n_clr    = r_clr;
        n_strobe = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        w_we     = 1'b0;
        w_waddr  = r_addr;
        w_wdata  = w_merged;
        case (r_state)
            BK_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 8'h00;
                n_clr   = r_clr + AW'(1);
                if (r_clr == {AW{1'b1}}) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_head_valid) begin
                    o_pop    = 1'b1;
                    n_op     = i_head;
                    n_second = 1'b0;
                    n_addr   = op_addr(i_head, 1'b0);
                    n_state  = BK_FETCH;
                end
            end
            BK_FETCH: begin
                n_state = BK_MERGE;
            end
            BK_MERGE: begin
                w_we            = 1'b1;
                n_strobe        = 1'b1;
                n_result.chip   = 1'(r_op.chip);
                n_result.page   = 3'(w_page);
                n_result.column = 6'(r_op.col);
                n_result.value  = w_merged;
                n_result.last   = !(r_op.spill && !r_second);
                if (r_op.spill && !r_second) begin
                    n_second = 1'b1;
                    n_addr   = op_addr(r_op, 1'b1);
                    n_state  = BK_FETCH;
                end else if (i_head_valid) begin
                    o_pop    = 1'b1;
                    n_op     = i_head;
                    n_second = 1'b0;
                    n_addr   = op_addr(i_head, 1'b0);
                    n_state  = BK_FETCH;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_CLEAR;
            r_clr    <= '0;
            r_second <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_second <= n_second;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[r_addr];
    end

    assign o_clearing = (r_state == BK_CLEAR);
    assign o_strobe   = r_strobe;
    assign o_result   = r_result;

endmodule

@@ rtl/core/paged_lcd_byte_blit_core.sv @@
// ----------------------------------------------------------------------------
// paged_lcd_byte_blit_core
// merges vertical pixel bytes into a paged monochrome framebuffer
// ----------------------------------------------------------------------------
// flow: a word enters the two-entry queue, the back end pops it, then fetches
//   and merges each written byte (two bytes for a word with spill) and pops
//   the next queued word while merging the last byte; results are registered
// reset: busy while all 2**(chip+page+column address bits) framebuffer
//   bytes are cleared; results cannot stall
// ----------------------------------------------------------------------------
module paged_lcd_byte_blit_core #(
    parameter int CHIP_COLUMNS = 64,
    parameter int CHIP_COUNT   = 2,
    parameter int PAGE_COUNT   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  plbb_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    output logic              o_strobe,
    output plbb_pkg::t_result o_result
);
    import plbb_pkg::*;

    t_mode r_mode;
    t_op   w_head;
    logic  w_head_valid;
    logic  w_full;
    logic  w_pop;
    logic  w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_REPLACE;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_data);
        end
    end

    assign busy = w_full || w_clearing;

    plbb_front #(
        .CHIP_COLUMNS (CHIP_COLUMNS),
        .CHIP_COUNT   (CHIP_COUNT),
        .PAGE_COUNT   (PAGE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (start && !busy),
        .i_item       (i_item),
        .i_mode       (r_mode),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .o_full       (w_full)
    );

    plbb_back #(
        .CHIP_COLUMNS (CHIP_COLUMNS),
        .CHIP_COUNT   (CHIP_COUNT),
        .PAGE_COUNT   (PAGE_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

endmodule

@@ rtl/core/plbb_checker.sv @@
// ----------------------------------------------------------------------------
// plbb_checker
// port-level checks of the paged lcd byte blit core
// ----------------------------------------------------------------------------
module plbb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              busy,
    input logic              o_strobe,
    input plbb_pkg::t_result o_result
);
    import plbb_pkg::*;

    // framebuffer clear starts right after reset
    a_busy_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> busy
    ) else $error("busy low after reset");

    a_quiet_after_reset: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_strobe
    ) else $error("result word during reset");

    // each written byte passes through a fetch and a merge state
    a_strobe_gap: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe
    ) else $error("result words back to back");

    // a spill word follows after another fetch and merge, in the next page of the same chip and column
    a_spill_follows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> ##2 (o_strobe && o_result.last &&
            o_result.chip == $past(o_result.chip, 2) &&
            o_result.column == $past(o_result.column, 2) &&
            o_result.page == $past(o_result.page, 2) + 3'd1)
    ) else $error("spill word missing or misplaced");

endmodule

bind paged_lcd_byte_blit_core plbb_checker u_plbb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

@@ test/paged_lcd_byte_blit_core_tb.sv @@
// ----------------------------------------------------------------------------
// paged_lcd_byte_blit_core_tb
// drives pixel bytes and raster-mode writes into the blit core and checks
// every framebuffer word it emits against a local shadow of the framebuffer
// ----------------------------------------------------------------------------
module paged_lcd_byte_blit_core_tb;
    import plbb_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int CHIP_COLUMNS   = 64;
    localparam int CHIP_COUNT     = 2;
    localparam int PAGE_COUNT     = 8;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_ITEMS    = 75;

    // draw modes with no merge behind them
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        STEP_BLIT,
        STEP_MODE,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        t_item      item;
        logic [2:0] mode;
        int         gap;
    } t_step;

    logic    i_clk      = 1'b0;
    logic    i_rst_n    = 1'b0;
    logic    start      = 1'b0;
    t_item   i_item     = '0;
    logic    i_cfg_we   = 1'b0;
    logic    [2:0] i_cfg_data = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    t_step      blit_script[$];
    t_result    expected_writes[$];
    logic [7:0] shadow_frame [CHIP_COUNT*PAGE_COUNT*CHIP_COLUMNS];
    logic [2:0] shadow_mode = MODE_REPLACE;
    int         error_count = 0;
    int         quiet_cycles = 0;
    int         gap_count = 0;
    bit         no_gaps = 1'b0;

    paged_lcd_byte_blit_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    function automatic logic [7:0] merge_pixels(input logic [7:0] old_byte,
                                                input logic [7:0] placed,
                                                input logic [7:0] keep_mask,
                                                input logic [7:0] inv_placed);
        case (shadow_mode)
            MODE_OR:      return old_byte | placed;
            MODE_XOR:     return old_byte ^ placed;
            MODE_INV_OR:  return old_byte | inv_placed;
            MODE_INV_XOR: return old_byte ^ inv_placed;
            default:      return (old_byte & keep_mask) | placed;
        endcase
    endfunction

    // read-modify-write of the shadow framebuffer, one expected word per byte
    task automatic predict_blit(input t_item it);
        int      chip_no;
        int      col;
        int      pg;
        int      sh;
        int      data;
        int      inv;
        int      addr;
        logic    spill;
        t_result w;
        if (it.pos_x >= CHIP_COLUMNS * CHIP_COUNT || it.pos_y >= PAGE_COUNT * PAGE_ROWS)
            return;
        if (shadow_mode > MODE_REPLACE)
            return;
        chip_no = it.pos_x / CHIP_COLUMNS;
        col     = it.pos_x % CHIP_COLUMNS;
        pg      = it.pos_y / PAGE_ROWS;
        sh      = it.pos_y % PAGE_ROWS;
        data    = it.pixel_byte;
        inv     = data ^ 32'hFF;
        spill   = (sh != 0) && (pg + 1 < PAGE_COUNT);

        addr = (chip_no * PAGE_COUNT + pg) * CHIP_COLUMNS + col;
        shadow_frame[addr] = merge_pixels(shadow_frame[addr], 8'(data << sh),
                                          8'(32'hFF >> (8 - sh)), 8'(inv << sh));
        w.chip   = chip_no[0];
        w.page   = pg[2:0];
        w.column = col[5:0];
        w.value  = shadow_frame[addr];
        w.last   = !spill;
        expected_writes.push_back(w);
        if (!spill)
            return;

        addr = (chip_no * PAGE_COUNT + pg + 1) * CHIP_COLUMNS + col;
        shadow_frame[addr] = merge_pixels(shadow_frame[addr], 8'(data >> (8 - sh)),
                                          8'(32'hFF << sh), 8'(inv >> (8 - sh)));
        w.page  = 3'(pg + 1);
        w.value = shadow_frame[addr];
        w.last  = 1'b1;
        expected_writes.push_back(w);
    endtask

    function automatic int pick_gap();
        return no_gaps ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic add_blit(input logic [7:0] x, input logic [7:0] y, input logic [7:0] d);
        t_step s;
        s.kind = STEP_BLIT;
        s.item = '{pos_x: x, pos_y: y, pixel_byte: d};
        s.mode = '0;
        s.gap  = pick_gap();
        blit_script.push_back(s);
    endtask

    task automatic add_mode(input logic [2:0] m);
        t_step s;
        s.kind = STEP_MODE;
        s.item = '0;
        s.mode = m;
        s.gap  = 0;
        blit_script.push_back(s);
    endtask

    task automatic add_drain();
        t_step s;
        s.kind = STEP_DRAIN;
        s.item = '0;
        s.mode = '0;
        s.gap  = 0;
        blit_script.push_back(s);
    endtask

    task automatic add_random_blit();
        int sel;
        logic [7:0] x;
        logic [7:0] y;
        sel = $urandom_range(0, 19);
        x   = 8'($urandom_range(0, 127));
        y   = 8'($urandom_range(0, 63));
        if (sel == 0) begin
            x = 8'($urandom_range(128, 255));
            y = 8'($urandom_range(0, 255));
        end else if (sel == 1) begin
            x = 8'($urandom_range(0, 255));
            y = 8'($urandom_range(64, 255));
        end else if (sel < 11) begin
            // hot window around the chip boundary so bytes get merged repeatedly
            x = 8'($urandom_range(60, 67));
        end
        add_blit(x, y, 8'($urandom_range(0, 255)));
    endtask

    // driver: one word at a time, mode writes only once the core has gone quiet
    always @(posedge i_clk) begin : drive_words
        logic       issue;
        t_item      next_item;
        logic       cfg_we_next;
        logic [2:0] cfg_data_next;
        issue         = 1'b0;
        next_item     = i_item;
        cfg_we_next   = 1'b0;
        cfg_data_next = i_cfg_data;
        if (i_rst_n) begin
            if (start && !busy)
                predict_blit(i_item);
            if (!start && expected_writes.size() == 0)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (start && busy) begin
                issue = 1'b1;
            end else if (blit_script.size() != 0) begin
                case (blit_script[0].kind)
                    STEP_BLIT: begin
                        if (gap_count < blit_script[0].gap) begin
                            gap_count++;
                        end else begin
                            issue     = 1'b1;
                            next_item = blit_script[0].item;
                            gap_count = 0;
                            blit_script.delete(0);
                        end
                    end
                    STEP_MODE: begin
                        if (quiet_cycles >= SETTLE_CYCLES && !busy) begin
                            cfg_we_next   = 1'b1;
                            cfg_data_next = blit_script[0].mode;
                            shadow_mode   = blit_script[0].mode;
                            quiet_cycles  = 0;
                            blit_script.delete(0);
                        end
                    end
                    default: begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                            blit_script.delete(0);
                    end
                endcase
            end
        end
        start      <= issue;
        i_item     <= next_item;
        i_cfg_we   <= cfg_we_next;
        i_cfg_data <= cfg_data_next;
    end

    always @(posedge i_clk) begin : check_writes
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_writes.size() == 0) begin
                $error("unexpected word: chip %0d page %0d column %0d value %02h last %0d",
                       o_result.chip, o_result.page, o_result.column, o_result.value,
                       o_result.last);
                error_count++;
            end else begin
                want = expected_writes.pop_front();
                if (o_result.chip !== want.chip) begin
                    $error("chip: expected %0d, got %0d", want.chip, o_result.chip);
                    error_count++;
                end
                if (o_result.page !== want.page) begin
                    $error("page: expected %0d, got %0d", want.page, o_result.page);
                    error_count++;
                end
                if (o_result.column !== want.column) begin
                    $error("column: expected %0d, got %0d", want.column, o_result.column);
                    error_count++;
                end
                if (o_result.value !== want.value) begin
                    $error("value: expected %02h, got %02h", want.value, o_result.value);
                    error_count++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_result.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("paged_lcd_byte_blit_core_tb: done, errors");
        $finish;
    end

    initial begin
        logic [2:0] phase_modes [RANDOM_PHASES];
        phase_modes = '{MODE_OR, MODE_REPLACE, MODE_XOR, MODE_INV_OR, MODE_INV_XOR,
                        MODE_REPLACE};
        foreach (shadow_frame[i])
            shadow_frame[i] = 8'h00;

        // replace mode straight out of reset: corners, spill, dropped spill
        add_blit(8'd0,   8'd0,   8'hFF);
        add_blit(8'd127, 8'd63,  8'hFF);
        add_blit(8'd127, 8'd56,  8'hA5);
        add_blit(8'd0,   8'd7,   8'h81);
        add_blit(8'd64,  8'd3,   8'h3C);
        add_blit(8'd63,  8'd60,  8'h5A);
        add_blit(8'd128, 8'd0,   8'hFF);
        add_blit(8'd255, 8'd255, 8'hFF);
        add_blit(8'd0,   8'd64,  8'hFF);
        add_blit(8'd5,   8'd9,   8'h00);
        add_mode(MODE_OR);
        add_blit(8'd0,   8'd0,   8'h0F);
        add_blit(8'd0,   8'd4,   8'hF0);
        add_blit(8'd10,  8'd13,  8'h55);
        add_mode(MODE_XOR);
        add_blit(8'd0,   8'd0,   8'hFF);
        add_blit(8'd0,   8'd3,   8'hAA);
        add_mode(MODE_INV_OR);
        add_blit(8'd1,   8'd1,   8'h00);
        add_blit(8'd2,   8'd62,  8'h0F);
        add_mode(MODE_INV_XOR);
        add_blit(8'd0,   8'd0,   8'h00);
        add_blit(8'd127, 8'd63,  8'h80);
        // unused modes leave the framebuffer alone
        add_mode(MODE_SPARE_HI);
        add_blit(8'd0,   8'd0,   8'hFF);
        add_blit(8'd3,   8'd3,   8'h03);
        add_mode(MODE_SPARE_LO);
        add_blit(8'd0,   8'd0,   8'h01);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            no_gaps = (p == 2);
            add_mode(phase_modes[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2)
                    add_drain();
                add_random_blit();
            end
        end
        add_drain();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (blit_script.size() != 0 || start || expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("paged_lcd_byte_blit_core_tb: done, clean");
        else
            $display("paged_lcd_byte_blit_core_tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/plbb_pkg.sv
rtl/core/plbb_front.sv
rtl/core/plbb_back.sv
rtl/core/paged_lcd_byte_blit_core.sv
rtl/core/plbb_checker.sv
test/paged_lcd_byte_blit_core_tb.sv
